// ===== hdl/ant_next_node_roulette_select_assert.svh =====
// Assertion macros for the next-node selector checker
`ifndef ANT_NEXT_NODE_ROULETTE_SELECT_ASSERT_SVH
`define ANT_NEXT_NODE_ROULETTE_SELECT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ANRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("anrs assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define ANRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("anrs assertion failed");

`endif

// ===== hdl/anrs_pkg.sv =====
// Shared types and constants for the next-node roulette selector
package anrs_pkg;

  localparam int MAX_NODES_DEF    = 4096;
  localparam int MAX_CAND_DEF     = 32;
  localparam int PRODUCT_BITS_DEF = 32;
  localparam int RAND_BITS_DEF    = 24;
  localparam int STATUS_W         = 3;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_CAND   = 2'd1,
    REQ_BACKUP = 2'd2,
    REQ_VISIT  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_CHOSEN = 3'd0,
    STAT_BACKUP = 3'd1,
    STAT_SCAN   = 3'd2,
    STAT_REJECT = 3'd3,
    STAT_START  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MARK,
    S_MULT,
    S_SEARCH,
    S_FINISH
  } sel_state_t;

endpackage

// ===== hdl/anrs_ifc.sv =====
// Channel interfaces: request, result and configuration write
interface anrs_req_if #(
  parameter int NODE_W = 12,
  parameter int PROD_W = 32,
  parameter int RAND_W = 24
);
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [NODE_W-1:0] node;
  logic [PROD_W-1:0] product;
  logic              last;
  logic [RAND_W-1:0] rand_fraction;
  modport source (output valid, req_type, node, product, last, rand_fraction, input ready);
  modport sink (input valid, req_type, node, product, last, rand_fraction, output ready);
endinterface

interface anrs_res_if #(
  parameter int NODE_W = 12,
  parameter int CNT_W  = 13
);
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [NODE_W-1:0] sel_node;
  logic [CNT_W-1:0]  visited_count;
  logic              tour_done;
  modport source (output valid, status, sel_node, visited_count, tour_done, input ready);
  modport sink (input valid, status, sel_node, visited_count, tour_done, output ready);
endinterface

interface anrs_cfg_if #(
  parameter int CNT_W = 13
);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== hdl/ant_next_node_roulette_select.sv =====
// A candidate passes through the exec state; if any entry was kept, a last
// candidate goes on through multiply, search over the kept entries and finish.
// Backup and try-visit entries pass through exec alone, one result each at most.
// Start tour sweeps the visited memory, then marks the start node. One item at a time.
// Reset (rst, synchronous): clears control state and runs the same sweep; no
// request is taken until it ends, configuration writes are taken outside reset.
module ant_next_node_roulette_select #(
  parameter int MAX_NODES    = anrs_pkg::MAX_NODES_DEF,
  parameter int MAX_CAND     = anrs_pkg::MAX_CAND_DEF,
  parameter int PRODUCT_BITS = anrs_pkg::PRODUCT_BITS_DEF,
  parameter int RAND_BITS    = anrs_pkg::RAND_BITS_DEF
) (
  input logic clk,
  input logic rst,
  anrs_cfg_if.sink cfg,
  anrs_req_if.sink req,
  anrs_res_if.source res
);
  import anrs_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int IDX_W  = $clog2(MAX_CAND);
  localparam int VC_W   = $clog2(MAX_CAND + 1);
  localparam int SUM_W  = PRODUCT_BITS + IDX_W;
  localparam int MUL_W  = SUM_W + RAND_BITS;

  sel_state_t state, state_next;

  logic [CNT_W-1:0]        num_nodes;
  logic [NODE_W-1:0]       clr_addr;
  logic                    start_pend;
  logic [1:0]              h_type;
  logic [NODE_W-1:0]       h_node;
  logic [PRODUCT_BITS-1:0] h_prod;
  logic                    h_last;
  logic [RAND_BITS-1:0]    h_rnd;
  logic [VC_W-1:0]         vc;
  logic [SUM_W-1:0]        run_sum;
  logic [NODE_W-1:0]       cur_node;
  logic [CNT_W-1:0]        visit_total;
  logic                    awaiting;
  logic [SUM_W-1:0]        thresh;
  logic [IDX_W-1:0]        sidx;
  logic [NODE_W-1:0]       chosen;

  logic                    vis_mem [MAX_NODES];
  logic                    vis_rd;
  logic [NODE_W-1:0]       node_mem [MAX_CAND];
  logic [SUM_W-1:0]        sum_mem [MAX_CAND];
  logic [NODE_W-1:0]       nd_rd;
  logic [SUM_W-1:0]        ps_rd;

  logic                    accept;
  logic                    out_free;
  logic                    append;
  logic [SUM_W-1:0]        sum_add;
  logic [VC_W-1:0]         vc_new;
  logic                    hit;
  logic [MUL_W-1:0]        mul;

  logic                    emit;
  status_t                 e_status;
  logic [NODE_W-1:0]       e_node;
  logic [CNT_W-1:0]        e_count;
  logic                    go;
  logic                    vis_we;
  logic [NODE_W-1:0]       vis_wa;
  logic                    vis_wd;
  logic                    cand_re;
  logic [IDX_W-1:0]        rd_idx;

  assign cfg.ready = !rst;
  assign req.ready = (state == S_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign out_free  = !res.valid || res.ready;

  assign append  = (h_type == REQ_CAND) && !vis_rd && (vc < VC_W'(MAX_CAND));
  assign sum_add = run_sum + SUM_W'(h_prod);
  assign vc_new  = vc + VC_W'(append);
  assign hit     = (thresh < ps_rd) || (sidx == IDX_W'(vc - VC_W'(1)));
  assign mul     = MUL_W'(h_rnd) * MUL_W'(run_sum);
  assign go      = !emit || out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_addr == NODE_W'(MAX_NODES - 1)) begin
          state_next = start_pend ? S_MARK : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (req.req_type == REQ_START) ? S_CLEAR : S_EXEC;
        end
      end
      S_EXEC: begin
        if (go) begin
          if (h_type == REQ_CAND && h_last && vc_new != '0) begin
            state_next = S_MULT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_MARK: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      S_MULT: state_next = S_SEARCH;
      S_SEARCH: begin
        if (hit) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    emit     = 1'b0;
    e_status = STAT_CHOSEN;
    e_node   = cur_node;
    e_count  = visit_total;
    vis_we   = 1'b0;
    vis_wa   = h_node;
    vis_wd   = 1'b1;
    cand_re  = 1'b0;
    rd_idx   = '0;
    unique case (state)
      S_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_addr;
        vis_wd = 1'b0;
      end
      S_EXEC: begin
        unique case (h_type)
          REQ_CAND: begin
            if (h_last && vc_new == '0) begin
              emit     = 1'b1;
              e_status = STAT_BACKUP;
            end
          end
          REQ_BACKUP: begin
            if (awaiting && !vis_rd) begin
              emit    = 1'b1;
              e_node  = h_node;
              e_count = visit_total + CNT_W'(1);
              vis_we  = 1'b1;
            end else if (awaiting && h_last) begin
              emit     = 1'b1;
              e_status = STAT_SCAN;
            end
          end
          REQ_VISIT: begin
            emit = 1'b1;
            if (vis_rd) begin
              e_status = STAT_REJECT;
            end else begin
              e_node  = h_node;
              e_count = visit_total + CNT_W'(1);
              vis_we  = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_MARK: begin
        emit     = 1'b1;
        e_status = STAT_START;
        e_node   = h_node;
        e_count  = CNT_W'(1);
        vis_we   = 1'b1;
      end
      S_MULT: cand_re = 1'b1;
      S_SEARCH: begin
        cand_re = !hit;
        rd_idx  = sidx + IDX_W'(1);
      end
      S_FINISH: begin
        emit    = 1'b1;
        e_node  = chosen;
        e_count = visit_total + CNT_W'(1);
        vis_we  = 1'b1;
        vis_wa  = chosen;
      end
      default: ;
    endcase
    if (!go) begin
      vis_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (accept) begin
      vis_rd <= vis_mem[req.node];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && go && append) begin
      node_mem[vc[IDX_W-1:0]] <= h_node;
      sum_mem[vc[IDX_W-1:0]]  <= sum_add;
    end
    if (cand_re) begin
      nd_rd <= node_mem[rd_idx];
      ps_rd <= sum_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_type <= req.req_type;
      h_node <= req.node;
      h_prod <= req.product;
      h_last <= req.last;
      h_rnd  <= req.rand_fraction;
    end
    if (state == S_MULT) begin
      thresh <= mul[RAND_BITS +: SUM_W];
      sidx   <= '0;
    end else if (state == S_SEARCH) begin
      if (hit) begin
        chosen <= nd_rd;
      end else begin
        sidx <= sidx + IDX_W'(1);
      end
    end
    if (emit && go) begin
      res.status        <= e_status;
      res.sel_node      <= e_node;
      res.visited_count <= e_count;
      res.tour_done     <= (e_count == num_nodes);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      start_pend  <= 1'b0;
      num_nodes   <= CNT_W'(MAX_NODES);
      vc          <= '0;
      run_sum     <= '0;
      cur_node    <= '0;
      visit_total <= '0;
      awaiting    <= 1'b0;
      res.valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        num_nodes <= cfg.data;
      end
      if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (emit && go) begin
        res.valid <= 1'b1;
      end
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
      if (accept && req.req_type == REQ_START) begin
        start_pend <= 1'b1;
        awaiting   <= 1'b0;
        clr_addr   <= '0;
      end
      if (go) begin
        unique case (state)
          S_EXEC: begin
            if (h_type == REQ_CAND) begin
              awaiting <= 1'b0;
              if (append) begin
                run_sum <= sum_add;
                vc      <= vc_new;
              end
              if (h_last && vc_new == '0) begin
                awaiting <= 1'b1;
                run_sum  <= '0;
              end
            end else if (vis_we) begin
              if (h_type == REQ_BACKUP) begin
                awaiting <= 1'b0;
              end
              cur_node    <= h_node;
              visit_total <= e_count;
            end else if (emit && e_status == STAT_SCAN) begin
              awaiting <= 1'b0;
            end
          end
          S_MARK: begin
            start_pend  <= 1'b0;
            cur_node    <= h_node;
            visit_total <= e_count;
            vc          <= '0;
            run_sum     <= '0;
          end
          S_FINISH: begin
            cur_node    <= chosen;
            visit_total <= e_count;
            vc          <= '0;
            run_sum     <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/anrs_check.sv =====
// Port-level checker for the next-node selector and its bind
`include "ant_next_node_roulette_select_assert.svh"

module anrs_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [12:0] visited_count
);
  import anrs_pkg::*;

  `ANRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `ANRS_ASSERT_NOW(a_status_legal, out_valid, status <= STAT_START)
  `ANRS_ASSERT_NOW(a_start_count, out_valid && status == STAT_START, visited_count == 13'd1)
  `ANRS_ASSERT_NOW(a_chosen_count, out_valid && status == STAT_CHOSEN, visited_count != 13'd0)

endmodule

bind ant_next_node_roulette_select anrs_check u_anrs_check (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .status        (res.status),
  .visited_count (res.visited_count)
);
